// ===== src/utf8_to_utf16_decoder_assert.svh =====
// assertion macros for the transcoder, empty under synthesis
`ifndef UTF8_TO_UTF16_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define U8D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked at every edge, reset included
`define U8D_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define U8D_ASSERT(label, prop, msg)
`define U8D_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== src/utf8d_pkg.sv =====
package utf8d_pkg;

  localparam int unsigned CODE_W = 21;

  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_PAT  = 8'hF0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_PAT  = 8'hE0;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_PAT  = 8'hC0;

  localparam logic [CODE_W-1:0] BMP_MAX   = 21'h00FFFF;
  localparam logic [CODE_W-1:0] SUPP_BASE = 21'h010000;
  localparam logic [CODE_W-1:0] HI_SURR   = 21'h00D800;
  localparam logic [CODE_W-1:0] LO_SURR   = 21'h00DC00;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } unit_t;

  // results caused by one input byte
  typedef struct packed {
    logic [1:0] count;
    unit_t      first;
    unit_t      second;
  } result_t;

endpackage

// ===== src/utf8d_core.sv =====
module utf8d_core
  import utf8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       accept,
  input  logic [7:0] byte_in,
  input  logic       end_of_string,
  output result_t    result
);

  logic              utf16_output;
  logic [1:0]        bytes_pending, bytes_pending_next;
  logic [CODE_W-1:0] code_accumulator, code_accumulator_next;

  logic [CODE_W-1:0] acc_shifted;
  logic [CODE_W-1:0] supp_offset;
  logic [CODE_W-1:0] hi_unit, lo_unit;

  assign acc_shifted = {code_accumulator[CODE_W-7:0], byte_in[5:0]};
  assign supp_offset = acc_shifted - SUPP_BASE;
  assign hi_unit     = HI_SURR + {10'd0, supp_offset[CODE_W-1:10]};
  assign lo_unit     = LO_SURR | {11'd0, acc_shifted[9:0]};

  always_comb begin
    bytes_pending_next    = bytes_pending;
    code_accumulator_next = code_accumulator;
    result.count          = 2'd0;
    result.first.code     = {13'd0, byte_in};
    result.first.last     = 1'b1;
    result.second.code    = lo_unit;
    result.second.last    = 1'b1;

    if (bytes_pending == PEND_NONE) begin
      if ((byte_in & LEAD4_MASK) == LEAD4_PAT) begin
        bytes_pending_next    = PEND_THREE;
        code_accumulator_next = {18'd0, byte_in[2:0]};
      end else if ((byte_in & LEAD3_MASK) == LEAD3_PAT) begin
        bytes_pending_next    = PEND_TWO;
        code_accumulator_next = {17'd0, byte_in[3:0]};
      end else if ((byte_in & LEAD2_MASK) == LEAD2_PAT) begin
        bytes_pending_next    = PEND_ONE;
        code_accumulator_next = {16'd0, byte_in[4:0]};
      end else begin
        // plain byte, stray continuation or invalid lead passes through
        result.count          = 2'd1;
        code_accumulator_next = '0;
      end
    end else begin
      bytes_pending_next    = bytes_pending - 2'd1;
      code_accumulator_next = acc_shifted;
      if (bytes_pending == PEND_ONE) begin
        code_accumulator_next = '0;
        if (acc_shifted > BMP_MAX && utf16_output) begin
          result.count       = 2'd2;
          result.first.code  = hi_unit;
          result.first.last  = 1'b0;
        end else begin
          result.count       = 2'd1;
          result.first.code  = acc_shifted;
        end
      end
    end

    // truncated sequence at end of string is dropped
    if (end_of_string && bytes_pending_next != PEND_NONE) begin
      bytes_pending_next    = PEND_NONE;
      code_accumulator_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      utf16_output     <= 1'b1;
      bytes_pending    <= PEND_NONE;
      code_accumulator <= '0;
    end else begin
      if (cfg_wr_en) begin
        utf16_output <= cfg_wr_data;
      end
      if (accept) begin
        bytes_pending    <= bytes_pending_next;
        code_accumulator <= code_accumulator_next;
      end
    end
  end

endmodule

// ===== src/utf8d_outbuf.sv =====
module utf8d_outbuf
  import utf8d_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t result,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output unit_t   out_unit
);

`include "utf8_to_utf16_decoder_assert.svh"

  logic [1:0] count;
  unit_t      head;
  unit_t      tail;
  logic       pop;

  assign pop       = (count != 2'd0) && out_ready;
  // room for a surrogate pair once this cycle's transfer is done
  assign can_push  = (count == 2'd0) || ((count == 2'd1) && out_ready);
  assign out_valid = (count != 2'd0);
  assign out_unit  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push) begin
      count <= result.count;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      head <= result.first;
      tail <= result.second;
    end else if (pop) begin
      head <= tail;
    end
  end

  `U8D_ASSERT(a_count_range, count != 2'd3, "output buffer count out of range")
  `U8D_ASSERT(a_push_room, push |-> (count == 2'd0 || (count == 2'd1 && out_ready)), "push without room")
  `U8D_ASSERT(a_high_has_low, (count != 2'd0 && !head.last) |-> count == 2'd2, "high surrogate without its low unit")
  `U8D_ASSERT_ALWAYS(a_reset_empty, rst |=> count == 2'd0, "output buffer not empty after reset")

endmodule

// ===== src/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 transcoder. One byte is taken per transfer on the slave side and each
// finished code point leaves as one unit on the master side, or as a high and low surrogate
// pair when utf16_output is set and the value is above 0xFFFF. A byte is accepted in every
// cycle while results drain at one unit per cycle; a byte that completes a surrogate pair
// holds the input, since the two-entry output buffer must be down to one unit being taken
// before the next byte can enter. The first unit shows in the cycle after the transfer.
// end_of_string (tlast) drops an unfinished sequence; overlong forms and unchecked
// continuation bytes are decoded as they come. utf16_output resets to 1 and is written
// through cfg_wr_en / cfg_wr_data, by the user only while the stream is idle; not enforced.
module utf8_to_utf16_decoder
  import utf8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // utf16_output
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_unit, [23:21] zero
  output logic        m_axis_tlast    // last_unit
);

  result_t result;
  unit_t   out_unit;
  logic    can_push;
  logic    accept;

  assign s_axis_tready = can_push;
  assign accept        = s_axis_tvalid && can_push;

  utf8d_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .accept        (accept),
    .byte_in       (s_axis_tdata),
    .end_of_string (s_axis_tlast),
    .result        (result)
  );

  utf8d_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .result    (result),
    .can_push  (can_push),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_unit  (out_unit)
  );

  assign m_axis_tdata = {3'd0, out_unit.code};
  assign m_axis_tlast = out_unit.last;

endmodule
